@@ hdl/ipe_pkg.sv @@
// ----------------------------------------------------------------------------
// ipe_pkg: shared types and codes of the indexed pixel palette expander
// Holds the queue entry layout, the resolved configuration bundle and the
// operation, register and pixel depth codes.
// ----------------------------------------------------------------------------
package ipe_pkg;

  // Operation codes of an input transaction.
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_BPP_CODE      = 2'd0;
  localparam logic [1:0] REG_PALETTE_COUNT = 2'd1;
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd3;

  // Pixel depth codes.
  localparam logic [1:0] BPP_1 = 2'd0;
  localparam logic [1:0] BPP_2 = 2'd1;
  localparam logic [1:0] BPP_4 = 2'd2;
  localparam logic [1:0] BPP_8 = 2'd3;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration after saturation into legal ranges.
  typedef struct packed {
    logic [1:0] code;
    logic [8:0] pal_count;
    logic [8:0] width;
    logic [8:0] height;
  } ipe_cfg_t;

  // One classified transaction on its way to the back end.
  typedef struct packed {
    logic        op;
    logic [7:0]  pal_index;
    logic [23:0] pal_bgr;
    logic [7:0]  pixel_byte;
    logic [7:0]  mask_bits;
    logic [3:0]  num_pixels;
    logic [7:0]  base_x;
    logic [7:0]  dest_row;
    logic        last_row;
  } ipe_entry_t;

endpackage

@@ hdl/ipe_ram.sv @@
// ----------------------------------------------------------------------------
// ipe_ram: generic simple dual port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ipe_ram #(
  parameter int WIDTH      = 24,
  parameter int DEPTH      = 256,
  parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_WIDTH-1:0] waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [ADDR_WIDTH-1:0] raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/ipe_front.sv @@
// ----------------------------------------------------------------------------
// ipe_front: input acceptance and classification
// Tracks the source byte position, drops pad bytes and works out how many
// pixels each byte yields and where they land.
// ----------------------------------------------------------------------------
module ipe_front
  import ipe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ipe_cfg_t    cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_bgr,
  input  logic [7:0]  pixel_byte,
  input  logic [7:0]  mask_bits,
  input  logic        q_full,
  output logic        q_push,
  output ipe_entry_t  q_entry
);

  logic [8:0]  byte_in_row, byte_in_row_next;
  logic [7:0]  source_row, source_row_next;
  logic        accept;
  logic        row_wrap;
  logic [7:0]  row_eff;
  logic [8:0]  byte_pre;
  logic [8:0]  byte_eff;
  logic [11:0] row_bits;
  logic [6:0]  row_words;
  logic [8:0]  stride;
  logic [11:0] x_base;
  logic [11:0] remain;
  logic [3:0]  per_byte;
  logic [3:0]  num_pixels;
  logic [8:0]  height_m1;
  logic [8:0]  row_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    row_bits  = 12'(cfg.width) << cfg.code;
    row_words = 7'((row_bits + 12'd31) >> 5);
    stride    = {row_words, 2'b00};

    row_wrap = {1'b0, source_row} >= cfg.height;
    row_eff  = row_wrap ? 8'd0 : source_row;
    byte_pre = row_wrap ? 9'd0 : byte_in_row;
    byte_eff = (byte_pre >= stride) ? 9'd0 : byte_pre;

    per_byte = 4'd8 >> cfg.code;
    x_base   = 12'(byte_eff) << (2'd3 - cfg.code);
    remain   = 12'(cfg.width) - x_base;
    if (x_base >= 12'(cfg.width)) begin
      num_pixels = 4'd0;
    end else if (remain >= 12'(per_byte)) begin
      num_pixels = per_byte;
    end else begin
      num_pixels = remain[3:0];
    end

    height_m1 = cfg.height - 9'd1;
    row_inc   = {1'b0, row_eff} + 9'd1;

    byte_in_row_next = byte_in_row;
    source_row_next  = source_row;
    if (accept && op == OP_PIXEL) begin
      if (byte_eff + 9'd1 >= stride) begin
        byte_in_row_next = 9'd0;
        source_row_next  = (row_inc >= cfg.height) ? 8'd0 : row_inc[7:0];
      end else begin
        byte_in_row_next = byte_eff + 9'd1;
        source_row_next  = row_eff;
      end
    end
  end

  always_comb begin
    q_entry.op         = op;
    q_entry.pal_index  = palette_index;
    q_entry.pal_bgr    = palette_bgr;
    q_entry.pixel_byte = pixel_byte;
    q_entry.mask_bits  = mask_bits;
    q_entry.num_pixels = num_pixels;
    q_entry.base_x     = x_base[7:0];
    q_entry.dest_row   = 8'(height_m1 - {1'b0, row_eff});
    q_entry.last_row   = {1'b0, row_eff} == height_m1;
  end

  // Pixel bytes that yield no pixel are consumed here.
  assign q_push = accept && (op == OP_PALETTE || num_pixels != 4'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row <= 9'd0;
      source_row  <= 8'd0;
    end else begin
      byte_in_row <= byte_in_row_next;
      source_row  <= source_row_next;
    end
  end

endmodule

@@ hdl/ipe_queue.sv @@
// ----------------------------------------------------------------------------
// ipe_queue: small show-ahead queue between front and back
// Register based; the head entry is visible while the queue is not empty.
// ----------------------------------------------------------------------------
module ipe_queue
  import ipe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ipe_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output ipe_entry_t head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ipe_entry_t        slots [DEPTH];
  logic [PW-1:0]     wptr, rptr;
  logic [CW-1:0]     count;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_entry = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/ipe_back.sv @@
// ----------------------------------------------------------------------------
// ipe_back: palette store and pixel expansion
// Performs palette writes and steps through the pixels of each byte, one per
// cycle while the consumer does not stall, into an output stage that holds while it stalls.
// ----------------------------------------------------------------------------
module ipe_back
  import ipe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  ipe_cfg_t   cfg,
  input  logic       head_valid,
  input  ipe_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic [7:0] alpha,
  output logic [7:0] column,
  output logic [7:0] dest_row,
  output logic       last_of_run,
  output logic       frame_done
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [2:0]  pix_k;
  logic        load;
  logic        issue;
  logic        wr_en;
  logic        last_pix;
  logic [7:0]  pix;
  logic        pix_masked;
  logic [7:0]  pix_gray;
  logic [7:0]  pix_x;
  logic [23:0] ram_q;

  logic        b_valid;
  logic        b_masked;
  logic        b_use_pal;
  logic [7:0]  b_gray;
  logic [7:0]  b_column;
  logic [7:0]  b_row;
  logic        b_last;
  logic        b_frame;

  assign load     = !b_valid || !out_stall;
  assign issue    = head_valid && head.op == OP_PIXEL && load;
  assign wr_en    = head_valid && head.op == OP_PALETTE
                    && {1'b0, head.pal_index} < 9'(PALETTE_ENTRIES);
  assign last_pix = {1'b0, pix_k} == head.num_pixels - 4'd1;
  assign pop      = (head_valid && head.op == OP_PALETTE) || (issue && last_pix);

  // Index and mask bit of pixel k, most significant first.
  always_comb begin
    unique case (cfg.code)
      BPP_1: begin
        pix      = {7'd0, head.pixel_byte[3'd7 - pix_k]};
        pix_gray = pix[0] ? 8'hff : 8'h00;
      end
      BPP_2: begin
        pix      = 8'((head.pixel_byte >> {2'd3 - pix_k[1:0], 1'b0}) & 8'h03);
        pix_gray = {4{pix[1:0]}};
      end
      BPP_4: begin
        pix      = {4'd0, pix_k[0] ? head.pixel_byte[3:0] : head.pixel_byte[7:4]};
        pix_gray = {2{pix[3:0]}};
      end
      default: begin
        pix      = head.pixel_byte;
        pix_gray = head.pixel_byte;
      end
    endcase
    pix_masked = head.mask_bits[3'd7 - pix_k];
    pix_x      = head.base_x + 8'(pix_k);
  end

  ipe_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (head.pal_index[AW-1:0]),
    .wdata (head.pal_bgr),
    .re    (issue),
    .raddr (pix[AW-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_k   <= 3'd0;
      b_valid <= 1'b0;
    end else begin
      if (issue) begin
        pix_k <= last_pix ? 3'd0 : pix_k + 3'd1;
      end
      if (load) begin
        b_valid <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_masked  <= pix_masked;
      b_use_pal <= {1'b0, pix} < cfg.pal_count;
      b_gray    <= pix_gray;
      b_column  <= pix_x;
      b_row     <= head.dest_row;
      b_last    <= last_pix;
      b_frame   <= head.last_row && {1'b0, pix_x} == cfg.width - 9'd1;
    end
  end

  always_comb begin
    if (b_masked) begin
      red   = 8'h00;
      green = 8'h00;
      blue  = 8'h00;
      alpha = 8'h00;
    end else if (b_use_pal) begin
      red   = ram_q[23:16];
      green = ram_q[15:8];
      blue  = ram_q[7:0];
      alpha = 8'hff;
    end else begin
      red   = b_gray;
      green = b_gray;
      blue  = b_gray;
      alpha = 8'hff;
    end
  end

  assign out_valid   = b_valid;
  assign column      = b_column;
  assign dest_row    = b_row;
  assign last_of_run = b_last;
  assign frame_done  = b_frame;

endmodule

@@ hdl/indexed_pixel_palette_expand_core.sv @@
// Path: an accepted pixel byte is written into the queue, and its first pixel is then registered into the output stage.
// Throughput: one pixel per cycle while the consumer does not stall; a byte holds the back end
// until all its pixels (up to 8, 4, 2 or 1 by depth) have passed the single pixel step and palette read.
// A pad byte is dropped by the front end; a palette write yields no pixel but occupies the back end.
// Reset: synchronous, active high; counters clear, registers take their defaults, and
// the palette store has no reset and must be written before it is looked up.
// ----------------------------------------------------------------------------
// indexed_pixel_palette_expand_core: indexed pixels to RGBA
// Expands packed palette indices of 1, 2, 4 or 8 bits with a transparency
// mask into RGBA pixels with destination coordinates.
// ----------------------------------------------------------------------------
module indexed_pixel_palette_expand_core
  import ipe_pkg::*;
#(
  parameter int MAX_DIMENSION   = 256,
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_bgr,
  input  logic [7:0]  pixel_byte,
  input  logic [7:0]  mask_bits,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [7:0]  column,
  output logic [7:0]  dest_row,
  output logic        last_of_run,
  output logic        frame_done
);

  // Raw register contents as written.
  logic [1:0] bits_per_pixel_code;
  logic [8:0] palette_count;
  logic [8:0] image_width;
  logic [8:0] image_height;

  ipe_cfg_t   cfg;

  logic       q_push;
  logic       q_full;
  ipe_entry_t q_entry;
  logic       q_pop;
  logic       q_head_valid;
  ipe_entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel_code <= BPP_8;
      palette_count       <= 9'd0;
      image_width         <= 9'd16;
      image_height        <= 9'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BPP_CODE:      bits_per_pixel_code <= cfg_data[1:0];
        REG_PALETTE_COUNT: palette_count       <= cfg_data;
        REG_IMAGE_WIDTH:   image_width         <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height        <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Saturate the registers into their legal ranges once, here, so that the
  // front and back ends see consistent values.
  always_comb begin
    cfg.code = bits_per_pixel_code;
    cfg.pal_count = (palette_count > 9'(PALETTE_ENTRIES)) ? 9'(PALETTE_ENTRIES)
                                                          : palette_count;
    if (image_width == 9'd0) begin
      cfg.width = 9'd1;
    end else if (image_width > 9'(MAX_DIMENSION)) begin
      cfg.width = 9'(MAX_DIMENSION);
    end else begin
      cfg.width = image_width;
    end
    if (image_height == 9'd0) begin
      cfg.height = 9'd1;
    end else if (image_height > 9'(MAX_DIMENSION)) begin
      cfg.height = 9'(MAX_DIMENSION);
    end else begin
      cfg.height = image_height;
    end
  end

  // The front end owns the row and byte counters; every transaction that has
  // work for the back end is pushed into the queue in arrival order, so a
  // palette write never overtakes a lookup that came before it.
  ipe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .palette_index (palette_index),
    .palette_bgr   (palette_bgr),
    .pixel_byte    (pixel_byte),
    .mask_bits     (mask_bits),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  ipe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_entry (q_head)
  );

  // The back end keeps the palette and emits one pixel per cycle, while the consumer does not
  // stall, into an output stage; the palette read data is held while the consumer stalls.
  ipe_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha       (alpha),
    .column      (column),
    .dest_row    (dest_row),
    .last_of_run (last_of_run),
    .frame_done  (frame_done)
  );

`ifndef ASSERT_OFF
  // The last pixel of the image is always the last pixel of its byte.
  a_frame_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_run)
    else $error("frame_done without last_of_run");

  // A transparent pixel carries no color.
  a_masked_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && alpha == 8'h00 |-> red == 8'h00 && green == 8'h00 && blue == 8'h00)
    else $error("transparent pixel with color");

  // Within one byte the pixels follow each other without a gap, column by column.
  a_run_is_contiguous: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run
    |=> out_valid && column == 8'($past(column) + 8'd1))
    else $error("pixel run broken");
`endif

endmodule
